// ----- hw/rtl/knn_pkg.sv -----
package knn_pkg;

  localparam int COORD_W = 16;
  localparam int IDX_W   = 16;
  localparam int SQ_W    = 38;
  localparam int PROD_W  = 32;
  localparam int ROOT_W  = 19;
  localparam int RANK_W  = 6;
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 17;

  localparam logic [SQ_W-1:0] SQ_MAX = '1;

  localparam logic FUNC_QUERY  = 1'b0;
  localparam logic FUNC_CORPUS = 1'b1;

  localparam logic [CFG_IW-1:0] REG_NUM_DIMS      = 2'd0;
  localparam logic [CFG_IW-1:0] REG_NUM_POINTS    = 2'd1;
  localparam logic [CFG_IW-1:0] REG_NUM_NEIGHBORS = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_INS,
    S_ROOT,
    S_OUT
  } knn_state_t;

  typedef struct packed {
    logic            valid;
    logic [SQ_W-1:0] dsq;
    logic [IDX_W-1:0] idx;
  } cell_t;

  typedef struct packed {
    logic clr;
    logic unload;
    logic ins;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/knn_ifs.sv -----
interface knn_in_if import knn_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [COORD_W-1:0] coord;
  modport source (output valid, output func, output coord, input ready);
  modport sink (input valid, input func, input coord, output ready);
endinterface

interface knn_out_if import knn_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RANK_W-1:0] rank;
  logic [IDX_W-1:0]  point_index;
  logic [SQ_W-1:0]   sq_dist;
  logic [ROOT_W-1:0] dist_res;
  logic              last;
  modport source (output valid, output rank, output point_index, output sq_dist,
                  output dist_res, output last, input ready);
  modport sink (input valid, input rank, input point_index, input sq_dist,
                input dist_res, input last, output ready);
endinterface

interface knn_cfg_if import knn_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [CFG_DW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/knn_ram.sv -----
module knn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/knn_cell.sv -----
module knn_cell import knn_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  logic       en,
  input  cell_t      cand,
  input  cell_t      left,
  input  logic       left_lt,
  input  cell_t      right,
  output cell_t      held,
  output logic       lt
);

  cell_t held_r, held_nxt;

  // strictly less: an equal distance stays behind the older, lower index
  assign lt   = !held_r.valid || (cand.dsq < held_r.dsq);
  assign held = held_r;

  always_comb begin
    held_nxt = held_r;
    priority if (ctrl.clr) begin
      held_nxt.valid = 1'b0;
    end else if (ctrl.unload) begin
      held_nxt = right;
    end else if (ctrl.ins && en) begin
      if (left_lt) begin
        held_nxt = left;
      end else if (lt) begin
        held_nxt = cand;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r.valid <= 1'b0;
    end else begin
      held_r <= held_nxt;
    end
  end

endmodule

// ----- hw/rtl/knn_isqrt.sv -----
module knn_isqrt import knn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SQ_W-1:0]   radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int REM_W = ROOT_W + 2;
  localparam int CNT_W = $clog2(ROOT_W);

  logic [SQ_W-1:0]   rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, done_r;
  logic [REM_W-1:0]  rem_s, test;

  // one result bit per cycle, two radicand bits shifted in
  assign rem_s = {rem_r[REM_W-3:0], rad_r[SQ_W-1 -: 2]};
  assign test  = {root_r, 2'b01};
  assign done  = done_r;
  assign root  = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rad_r <= {rad_r[SQ_W-3:0], 2'b00};
        if (rem_s >= test) begin
          rem_r  <= rem_s - test;
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= rem_s;
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/knn_top_k_distance_search.sv -----
// Query word: written to the query RAM, block stays ready. Corpus word: query RAM read,
// multiply, accumulate, then an insert step on the last coordinate of a point, which
// also enters the cell row; the block takes no new word until these steps are done.
// After the last point each neighbor takes a square root start, 19 root bits, done and an
// output slot, plus the wait for out ready. Reset (rst_n low, synchronous) sets
// all three registers to 1, empties the list and clears counters; the query RAM is kept.
module knn_top_k_distance_search import knn_pkg::*; #(
  parameter int MAX_NEIGHBORS = 64,
  parameter int MAX_DIMS      = 64,
  parameter int MAX_POINTS    = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  knn_in_if.sink      in_if,
  knn_out_if.source   out_if,
  knn_cfg_if.sink     cfg_if
);

  localparam int AW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int PW   = $clog2(MAX_POINTS + 1);
  localparam int NCEL = MAX_NEIGHBORS;

  knn_state_t state_r, state_nxt;

  // configuration registers
  logic [6:0]  num_dims_r, num_neighbors_r;
  logic [16:0] num_points_r;

  // scan state
  logic [AW-1:0]      dim_count_r, dc;
  logic               lastdim, lastdim_r;
  logic [PW-1:0]      point_count_r;
  logic [SQ_W-1:0]    acc_r;
  logic [PROD_W-1:0]  sq_r;
  logic [COORD_W-1:0] coord_r;
  logic [COORD_W-1:0] q_rdata;
  logic [RANK_W-1:0]  rank_r;

  // effective limits, clamped
  logic [31:0] dims32, pts32, k32;

  always_comb begin
    dims32 = {25'd0, num_dims_r};
    if (num_dims_r == 7'd0) dims32 = 32'd1;
    else if (dims32 > 32'(MAX_DIMS)) dims32 = 32'(MAX_DIMS);
    pts32 = {15'd0, num_points_r};
    if (num_points_r == 17'd0) pts32 = 32'd1;
    else if (pts32 > 32'(MAX_POINTS)) pts32 = 32'(MAX_POINTS);
    k32 = {25'd0, num_neighbors_r};
    if (num_neighbors_r == 7'd0) k32 = 32'd1;
    else if (k32 > 32'(MAX_NEIGHBORS)) k32 = 32'(MAX_NEIGHBORS);
    if (k32 > pts32) k32 = pts32;
  end

  // handshakes
  logic in_fire, cfg_fire, out_fire;
  logic cfg_hit;
  logic point_done;
  logic ram_we;
  logic root_start, root_done;
  logic root_go_r, root_go_nxt;
  logic [ROOT_W-1:0] root;
  cell_ctrl_t ctrl;

  assign in_fire  = in_if.valid && in_if.ready;
  assign cfg_fire = cfg_if.valid && cfg_if.ready;
  assign out_fire = out_if.valid && out_if.ready;

  // only the three known registers touch the scan; other indexes are dropped
  assign cfg_hit = (cfg_if.index == REG_NUM_DIMS) || (cfg_if.index == REG_NUM_POINTS) ||
                   (cfg_if.index == REG_NUM_NEIGHBORS);

  assign dc         = (32'(dim_count_r) < dims32) ? dim_count_r : '0;
  assign lastdim    = (32'(dc) + 32'd1) >= dims32;
  assign point_done = (32'(point_count_r) + 32'd1) >= pts32;

  // cell row: index NCEL is an always-empty sentinel past the end
  cell_t       cells [NCEL+1];
  logic [NCEL-1:0] lts;
  cell_t       cand;
  logic [SQ_W:0]   sum;

  assign cand.valid = 1'b1;
  assign cand.dsq   = acc_r;
  assign cand.idx   = IDX_W'(point_count_r);

  assign cells[NCEL].valid = 1'b0;
  assign cells[NCEL].dsq   = '0;
  assign cells[NCEL].idx   = '0;

  for (genvar i = 0; i < NCEL; i++) begin : g_cell
    cell_t left_c;
    logic  left_lt;
    if (i == 0) begin : g_head
      assign left_c  = cand;
      assign left_lt = 1'b0;
    end else begin : g_body
      assign left_c  = cells[i-1];
      assign left_lt = lts[i-1];
    end
    knn_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .en      (32'(i) < k32),
      .cand    (cand),
      .left    (left_c),
      .left_lt (left_lt),
      .right   (cells[i+1]),
      .held    (cells[i]),
      .lt      (lts[i])
    );
  end

  knn_ram #(
    .WIDTH (COORD_W),
    .DEPTH (MAX_DIMS)
  ) u_query_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (dc),
    .wdata (in_if.coord),
    .raddr (dc),
    .rdata (q_rdata)
  );

  // start the root in the cycle after the row settles, so the head is current
  assign root_start = root_go_r;

  knn_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (cells[0].dsq),
    .done     (root_done),
    .root     (root)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (!cfg_fire && in_fire && in_if.func == FUNC_CORPUS) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_ACC;
      S_ACC:  state_nxt = lastdim_r ? S_INS : S_IDLE;
      S_INS:  state_nxt = point_done ? S_ROOT : S_IDLE;
      S_ROOT: if (root_done) state_nxt = S_OUT;
      S_OUT:  if (out_fire) state_nxt = out_if.last ? S_IDLE : S_ROOT;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_if.ready  = 1'b0;
    cfg_if.ready = 1'b0;
    out_if.valid = 1'b0;
    ram_we       = 1'b0;
    root_go_nxt  = 1'b0;
    ctrl         = '0;
    unique case (state_r)
      S_IDLE: begin
        // a pending register write goes first; hold the input word meanwhile
        in_if.ready  = !cfg_if.valid;
        cfg_if.ready = 1'b1;
        ram_we       = !cfg_fire && in_fire && in_if.func == FUNC_QUERY;
        // a write to a known register or a query word drops any scan in progress
        ctrl.clr     = (cfg_fire && cfg_hit) || ram_we;
      end
      S_MUL, S_ACC, S_ROOT: ;
      S_INS: begin
        ctrl.ins    = 1'b1;
        root_go_nxt = point_done;
      end
      S_OUT: begin
        out_if.valid = 1'b1;
        ctrl.unload  = out_fire;
        root_go_nxt  = out_fire && !out_if.last;
      end
      default: ;
    endcase
  end

  assign sum = {1'b0, acc_r} + {{(SQ_W + 1 - PROD_W){1'b0}}, sq_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      num_dims_r      <= 7'd1;
      num_points_r    <= 17'd1;
      num_neighbors_r <= 7'd1;
      dim_count_r     <= '0;
      point_count_r   <= '0;
      acc_r           <= '0;
      rank_r          <= '0;
      root_go_r       <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      root_go_r <= root_go_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (cfg_fire) begin
            unique case (cfg_if.index)
              REG_NUM_DIMS:      num_dims_r      <= cfg_if.data[6:0];
              REG_NUM_POINTS:    num_points_r    <= cfg_if.data;
              REG_NUM_NEIGHBORS: num_neighbors_r <= cfg_if.data[6:0];
              default: ;
            endcase
            if (cfg_hit) begin
              dim_count_r   <= '0;
              point_count_r <= '0;
              acc_r         <= '0;
            end
          end else if (in_fire) begin
            dim_count_r <= lastdim ? '0 : dc + 1'b1;
            lastdim_r   <= lastdim;
            coord_r     <= in_if.coord;
            if (in_if.func == FUNC_QUERY) begin
              point_count_r <= '0;
              acc_r         <= '0;
            end
          end
        end
        S_MUL: begin
          logic signed [COORD_W:0] diff;
          logic [COORD_W:0]        mag;
          diff = $signed({coord_r[COORD_W-1], coord_r}) -
                 $signed({q_rdata[COORD_W-1], q_rdata});
          mag  = diff[COORD_W] ? 17'(-diff) : 17'(diff);
          sq_r <= mag[COORD_W-1:0] * mag[COORD_W-1:0];
        end
        S_ACC: acc_r <= sum[SQ_W] ? SQ_MAX : sum[SQ_W-1:0];
        S_INS: begin
          acc_r         <= '0;
          point_count_r <= point_done ? '0 : point_count_r + 1'b1;
        end
        S_ROOT: begin
          if (root_done) begin
            out_if.rank        <= rank_r;
            out_if.point_index <= cells[0].idx;
            out_if.sq_dist     <= cells[0].dsq;
            out_if.dist_res    <= root;
            out_if.last        <= !cells[1].valid;
          end
        end
        S_OUT: begin
          if (out_fire) rank_r <= out_if.last ? '0 : rank_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> cells[0].valid)
    else $error("result shown with empty head cell");

  a_corpus_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !cfg_fire && in_if.func == FUNC_CORPUS) |=> !in_if.ready)
    else $error("engine took a word while busy");

  a_root_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    root_done |-> state_r == S_ROOT)
    else $error("square root finished outside its wait state");
`endif

endmodule
